[hdl/integer_pixel_replication_upscaler_macros.svh]
// Assertion helpers for the upscaler. Each macro expects signals named clk
// and rst_n in the scope where it is used.
`ifndef INTEGER_PIXEL_REPLICATION_UPSCALER_MACROS_SVH
`define INTEGER_PIXEL_REPLICATION_UPSCALER_MACROS_SVH

// Same-cycle implication.
`define IPU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IPU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ipu_pkg.sv]
// ----------------------------------------------------------------------------
// ipu_pkg
// Shared types and constants of the integer pixel replication upscaler.
// ----------------------------------------------------------------------------
package ipu_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MAX_SCALE_DEF = 16;

    localparam int PIX_W      = 24;
    localparam int COLOR_W    = 8;
    localparam int SCALE_W    = 5;
    localparam int WIDTH_W    = 12;
    localparam int CFG_DATA_W = 12;
    localparam int REG_IDX_W  = 1;
    localparam int PAD_W      = 2;

    // register indexes of the configuration port
    localparam logic [REG_IDX_W-1:0] REG_SCALE        = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDTH = 1'b1;

    // request function codes
    localparam logic FUNC_PIXEL  = 1'b0;
    localparam logic FUNC_REPLAY = 1'b1;

    typedef enum logic [1:0] {
        KIND_PIXEL   = 2'd0,
        KIND_PAD     = 2'd1,
        KIND_REFUSED = 2'd2
    } kind_t;

    // one accepted request as handed from the control stage to the emitter
    typedef struct packed {
        logic               refused;
        logic               replay;
        logic               row_end;
        logic [SCALE_W-1:0] copies;
        logic [PAD_W-1:0]   pad;
        logic [PIX_W-1:0]   pix;
    } job_t;

endpackage

[hdl/integer_pixel_replication_upscaler.sv]
// When the emitter is idle, the first result of a request passes through the
// request register and then the output register.
// Throughput: unless the output stalls, one result per cycle, and with one
// result per request one new request per cycle. A request gives scale pixel
// results, plus 0..3 pad bytes at a row end (up to 18), or one when refused.
// Reset: row position, repeat count and config (scale 1, width 1) clear at
// once; the line store is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
// integer_pixel_replication_upscaler
// Nearest-neighbor integer upscaler for 24-bit pixel rows with a line store
// for vertical repeats and 4-byte row padding.
// ----------------------------------------------------------------------------
module integer_pixel_replication_upscaler import ipu_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_SCALE = MAX_SCALE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  func,
    input  logic [COLOR_W-1:0]    red,
    input  logic [COLOR_W-1:0]    green,
    input  logic [COLOR_W-1:0]    blue,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            kind,
    output logic [COLOR_W-1:0]    out_red,
    output logic [COLOR_W-1:0]    out_green,
    output logic [COLOR_W-1:0]    out_blue,
    output logic                  row_done,
    output logic                  last
);

`include "integer_pixel_replication_upscaler_macros.svh"

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic             ram_we;
    logic             ram_re;
    logic [AW-1:0]    ram_addr;
    logic [PIX_W-1:0] ram_wdata;
    logic [PIX_W-1:0] ram_rdata;
    logic             job_valid;
    job_t             job;
    job_t             job_px;
    logic             job_take;

    ipu_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE),
        .AW        (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .pix_in    ({red, green, blue}),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take)
    );

    ipu_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // replay takes its pixel from the store; read data holds while stalled
    always_comb
    begin
        job_px = job;
        if (job.replay)
        begin
            job_px.pix = ram_rdata;
        end
    end

    ipu_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job_px),
        .job_take  (job_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .row_done  (row_done),
        .last      (last)
    );

    `IPU_ASSERT_NOW(a_refused_single, out_valid && (kind == KIND_REFUSED), last && !row_done, "refused request must give one final result without row end")
    `IPU_ASSERT_NOW(a_row_done_last, out_valid && row_done, last, "row end must fall on the final result of a request")
    `IPU_ASSERT_NEXT(a_no_gap, out_valid && out_ready && !last, out_valid, "results of one request must follow without a gap")
    `IPU_ASSERT_NOW(a_pad_zero, out_valid && (kind == KIND_PAD), (out_red == '0) && (out_green == '0) && (out_blue == '0), "pad bytes must carry zero color")

endmodule

[hdl/ipu_ram.sv]
// ----------------------------------------------------------------------------
// ipu_ram
// Generic single-port RAM with registered read and read enable.
// ----------------------------------------------------------------------------
module ipu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                      wdata,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/ipu_ctrl.sv]
// ----------------------------------------------------------------------------
// ipu_ctrl
// Configuration registers, row position and repeat tracking, line store
// addressing and the request stage that feeds the emitter.
// ----------------------------------------------------------------------------
module ipu_ctrl import ipu_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_SCALE = MAX_SCALE_DEF,
    parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  func,
    input  logic [PIX_W-1:0]      pix_in,
    output logic                  ram_we,
    output logic                  ram_re,
    output logic [AW-1:0]         ram_addr,
    output logic [PIX_W-1:0]      ram_wdata,
    output logic                  job_valid,
    output job_t                  job,
    input  logic                  job_take
);

    localparam int CMPW = (AW + 1 > WIDTH_W) ? AW + 1 : WIDTH_W;

    logic [SCALE_W-1:0] scale_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic [AW-1:0]      col_reg;
    logic [SCALE_W-1:0] rep_reg;
    logic               replaying_reg;
    logic               job_valid_reg;
    job_t               job_reg;

    logic [AW-1:0]      col_next;
    logic [SCALE_W-1:0] rep_next;
    logic               replaying_next;
    logic               job_valid_next;

    logic [SCALE_W-1:0] eff_s;
    logic [CMPW-1:0]    eff_w;
    logic [CMPW-1:0]    width_x;
    logic [CMPW-1:0]    col_inc;
    logic [SCALE_W-1:0] rep_dec;
    logic [PAD_W-1:0]   pad_c;
    logic               accept;
    logic               ok;
    logic               row_end;

    // clamp configuration to the supported range
    always_comb
    begin
        width_x = CMPW'(width_reg);
        if (scale_reg == '0)
        begin
            eff_s = SCALE_W'(1);
        end
        else if ({1'b0, scale_reg} > (SCALE_W + 1)'(MAX_SCALE))
        begin
            eff_s = SCALE_W'(MAX_SCALE);
        end
        else
        begin
            eff_s = scale_reg;
        end

        if (width_x == '0)
        begin
            eff_w = CMPW'(1);
        end
        else if (width_x > CMPW'(MAX_WIDTH))
        begin
            eff_w = CMPW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = width_x;
        end
    end

    // output row bytes are 3*w*s, so the pad count is w*s mod 4
    assign pad_c = PAD_W'(eff_w[PAD_W-1:0] * eff_s[PAD_W-1:0]);

    assign in_ready = !job_valid_reg || job_take;
    assign accept   = in_valid && in_ready;
    assign ok       = (func == replaying_reg);
    assign col_inc  = CMPW'(col_reg) + CMPW'(1);
    assign row_end  = (col_inc >= eff_w);
    assign rep_dec  = (rep_reg != '0) ? rep_reg - SCALE_W'(1) : '0;

    // one store access per request, so a write and a read never meet
    assign ram_we    = accept && ok && (func == FUNC_PIXEL);
    assign ram_re    = accept && ok && (func == FUNC_REPLAY);
    assign ram_addr  = col_reg;
    assign ram_wdata = pix_in;

    always_comb
    begin
        col_next       = col_reg;
        rep_next       = rep_reg;
        replaying_next = replaying_reg;
        job_valid_next = job_valid_reg;

        if (job_take)
        begin
            job_valid_next = 1'b0;
        end
        if (accept)
        begin
            job_valid_next = 1'b1;
        end

        if (accept && ok)
        begin
            if (row_end)
            begin
                col_next = '0;
                if (func == FUNC_PIXEL)
                begin
                    if (eff_s > SCALE_W'(1))
                    begin
                        rep_next       = eff_s - SCALE_W'(1);
                        replaying_next = 1'b1;
                    end
                end
                else
                begin
                    rep_next = rep_dec;
                    if (rep_dec == '0)
                    begin
                        replaying_next = 1'b0;
                    end
                end
            end
            else
            begin
                col_next = col_inc[AW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= SCALE_W'(1);
            width_reg     <= WIDTH_W'(1);
            col_reg       <= '0;
            rep_reg       <= '0;
            replaying_reg <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SCALE:        scale_reg <= cfg_data[SCALE_W-1:0];
                    REG_SOURCE_WIDTH: width_reg <= cfg_data[WIDTH_W-1:0];
                    default:          ;
                endcase
            end
            col_reg       <= col_next;
            rep_reg       <= rep_next;
            replaying_reg <= replaying_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg.refused <= !ok;
            job_reg.replay  <= (func == FUNC_REPLAY);
            job_reg.row_end <= ok && row_end;
            job_reg.copies  <= eff_s;
            job_reg.pad     <= pad_c;
            job_reg.pix     <= pix_in;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

[hdl/ipu_emit.sv]
// ----------------------------------------------------------------------------
// ipu_emit
// Result sequencer: expands one request into its pixel copies and pad bytes, or
// a refusal result, one per cycle while out_ready allows, via the output register.
// ----------------------------------------------------------------------------
module ipu_emit import ipu_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  job_t               job,
    output logic               job_take,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic [COLOR_W-1:0] out_red,
    output logic [COLOR_W-1:0] out_green,
    output logic [COLOR_W-1:0] out_blue,
    output logic               row_done,
    output logic               last
);

    logic [SCALE_W-1:0] cur_c_reg;
    logic [PAD_W-1:0]   cur_p_reg;
    logic [PIX_W-1:0]   cur_pix_reg;
    logic               cur_row_end_reg;
    logic               out_valid_reg;
    kind_t              kind_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic               row_done_reg;
    logic               last_reg;

    logic               cur_busy;
    logic               slot_free;
    logic               advance;
    logic               src_refused;
    logic [SCALE_W-1:0] src_c;
    logic [PAD_W-1:0]   src_p;
    logic [PIX_W-1:0]   src_pix;
    logic               src_row_end;
    logic [SCALE_W-1:0] nc;
    logic [PAD_W-1:0]   np;
    kind_t              res_kind;
    logic [PIX_W-1:0]   res_pix;
    logic               res_last;

    assign cur_busy  = (cur_c_reg != '0) || (cur_p_reg != '0);
    assign slot_free = !out_valid_reg || out_ready;
    assign advance   = slot_free && (cur_busy || job_valid);
    assign job_take  = slot_free && !cur_busy && job_valid;

    // continue the running request, else start the waiting one
    always_comb
    begin
        if (cur_busy)
        begin
            src_refused = 1'b0;
            src_c       = cur_c_reg;
            src_p       = cur_p_reg;
            src_pix     = cur_pix_reg;
            src_row_end = cur_row_end_reg;
        end
        else
        begin
            src_refused = job.refused;
            src_c       = job.copies;
            src_p       = job.row_end ? job.pad : '0;
            src_pix     = job.pix;
            src_row_end = job.row_end;
        end

        nc       = '0;
        np       = '0;
        res_pix  = '0;
        if (src_refused)
        begin
            res_kind = KIND_REFUSED;
        end
        else if (src_c != '0)
        begin
            res_kind = KIND_PIXEL;
            res_pix  = src_pix;
            nc       = src_c - SCALE_W'(1);
            np       = src_p;
        end
        else
        begin
            res_kind = KIND_PAD;
            np       = src_p - PAD_W'(1);
        end
        res_last = (nc == '0) && (np == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cur_c_reg     <= '0;
            cur_p_reg     <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                cur_c_reg     <= nc;
                cur_p_reg     <= np;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cur_pix_reg     <= src_pix;
            cur_row_end_reg <= src_row_end;
            kind_reg        <= res_kind;
            pix_reg         <= res_pix;
            row_done_reg    <= res_last && src_row_end && !src_refused;
            last_reg        <= res_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign out_red   = pix_reg[3*COLOR_W-1:2*COLOR_W];
    assign out_green = pix_reg[2*COLOR_W-1:COLOR_W];
    assign out_blue  = pix_reg[COLOR_W-1:0];
    assign row_done  = row_done_reg;
    assign last      = last_reg;

endmodule

[tb/sv/tb_integer_pixel_replication_upscaler.sv]
// ----------------------------------------------------------------------------
// tb_integer_pixel_replication_upscaler
// Self-checking bench for the pixel replication upscaler. A behavioral
// model of the line store, row position and owed repeats predicts every
// copy, pad byte and refusal; a result sink with random stalls compares
// each one in order against the prediction.
// ----------------------------------------------------------------------------
module tb_integer_pixel_replication_upscaler;
    timeunit 1ns;
    timeprecision 1ps;

    import ipu_pkg::*;

    typedef struct {
        kind_t              kind;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               row_done;
        logic               last;
    } upscale_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [REG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  func      = FUNC_PIXEL;
    logic [COLOR_W-1:0]    red       = '0;
    logic [COLOR_W-1:0]    green     = '0;
    logic [COLOR_W-1:0]    blue      = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            kind;
    logic [COLOR_W-1:0]    out_red;
    logic [COLOR_W-1:0]    out_green;
    logic [COLOR_W-1:0]    out_blue;
    logic                  row_done;
    logic                  last;

    // behavioral copy of the block state
    logic [PIX_W-1:0]      line_copy [MAX_WIDTH_DEF];
    int                    row_pos      = 0;
    int                    rows_owed    = 0;
    logic                  replaying_now = 1'b0;
    logic [SCALE_W-1:0]    scale_reg    = 5'd1;
    logic [WIDTH_W-1:0]    width_reg    = 12'd1;

    upscale_result_t       expected_results [$];
    int                    mismatches = 0;
    bit                    tx_idle    = 1'b0;
    bit                    rx_idle    = 1'b0;
    int                    rx_hold    = 0;

    integer_pixel_replication_upscaler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .row_done  (row_done),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clamp_scale(input logic [SCALE_W-1:0] s);
        if (s == 0)
            return 1;
        if (s > MAX_SCALE_DEF)
            return MAX_SCALE_DEF;
        return int'(s);
    endfunction

    function automatic int clamp_width(input logic [WIDTH_W-1:0] w);
        if (w == 0)
            return 1;
        if (w > MAX_WIDTH_DEF)
            return MAX_WIDTH_DEF;
        return int'(w);
    endfunction

    function automatic logic [COLOR_W-1:0] rand_color();
        return COLOR_W'($urandom);
    endfunction

    // Work out every result of one accepted request and queue it.
    function automatic void predict_upscale(input logic f, input logic [COLOR_W-1:0] r,
                                            input logic [COLOR_W-1:0] g,
                                            input logic [COLOR_W-1:0] b);
        upscale_result_t batch [$];
        logic [PIX_W-1:0] pix;
        logic             row_end;
        int               copies;
        int               width_px;
        int               pad;
        copies   = clamp_scale(scale_reg);
        width_px = clamp_width(width_reg);
        if (f != replaying_now)
        begin
            expected_results.push_back('{KIND_REFUSED, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1});
            return;
        end
        if (row_pos >= MAX_WIDTH_DEF)
            row_pos = 0;
        if (f == FUNC_PIXEL)
        begin
            pix = {r, g, b};
            line_copy[row_pos] = pix;
        end
        else
            pix = line_copy[row_pos];
        row_pos++;
        row_end = (row_pos >= width_px);
        if (row_end)
        begin
            row_pos = 0;
            if (f == FUNC_PIXEL)
            begin
                if (copies > 1)
                begin
                    rows_owed     = copies - 1;
                    replaying_now = 1'b1;
                end
            end
            else
            begin
                if (rows_owed > 0)
                    rows_owed--;
                if (rows_owed == 0)
                    replaying_now = 1'b0;
            end
        end
        for (int i = 0; i < copies; i++)
            batch.push_back('{KIND_PIXEL, pix[23:16], pix[15:8], pix[7:0], 1'b0, 1'b0});
        if (row_end)
        begin
            pad = (4 - (width_px * copies * 3) % 4) % 4;
            for (int i = 0; i < pad; i++)
                batch.push_back('{KIND_PAD, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0});
            batch[batch.size()-1].row_done = 1'b1;
        end
        batch[batch.size()-1].last = 1'b1;
        foreach (batch[i])
            expected_results.push_back(batch[i]);
    endfunction

    task automatic send_request(input logic f, input logic [COLOR_W-1:0] r,
                                input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        red      <= r;
        green    <= g;
        blue     <= b;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        predict_upscale(f, r, g, b);
    endtask

    task automatic drain_requests();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Write both registers once the block has gone quiet.
    task automatic configure(input logic [CFG_DATA_W-1:0] new_scale,
                             input logic [CFG_DATA_W-1:0] new_width);
        logic [CFG_DATA_W-1:0] width_val;
        drain_requests();
        width_val = new_width;
        // growing the row during repeats would replay columns never stored
        if (replaying_now && clamp_width(new_width) > clamp_width(width_reg))
            width_val = width_reg;
        cfg_write <= 1'b1;
        cfg_index <= REG_SCALE;
        cfg_data  <= new_scale;
        @(posedge clk);
        scale_reg = new_scale[SCALE_W-1:0];
        cfg_index <= REG_SOURCE_WIDTH;
        cfg_data  <= width_val;
        @(posedge clk);
        width_reg = width_val;
        cfg_write <= 1'b0;
    endtask

    task automatic test_directed();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        // reset values: scale 1, width 1, so every pixel closes a row
        send_request(FUNC_PIXEL, 8'h00, 8'h00, 8'h00);
        send_request(FUNC_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_request(FUNC_REPLAY, 8'hFF, 8'h00, 8'hFF);
        // zero registers act as one
        configure(12'd0, 12'd0);
        send_request(FUNC_PIXEL, 8'hA5, 8'h5A, 8'hC3);
        configure(12'd2, 12'd3);
        send_request(FUNC_PIXEL, 8'h12, 8'h34, 8'h56);
        send_request(FUNC_PIXEL, 8'h80, 8'h01, 8'h7F);
        send_request(FUNC_PIXEL, 8'hFE, 8'hDC, 8'hBA);
        send_request(FUNC_PIXEL, 8'h55, 8'hAA, 8'h55);
        for (int i = 0; i < 3; i++)
            send_request(FUNC_REPLAY, rand_color(), rand_color(), rand_color());
        // oversized registers saturate
        configure(12'd17, 12'd4095);
        for (int i = 0; i < 3; i++)
            send_request(FUNC_PIXEL, rand_color(), rand_color(), rand_color());
        // shrink mid-row: the next pixel ends the row at once
        configure(12'd1, 12'd2);
        send_request(FUNC_PIXEL, 8'h0F, 8'hF0, 8'h3C);
        // fifteen copies plus three pad bytes
        configure(12'd15, 12'd1);
        send_request(FUNC_PIXEL, 8'hC0, 8'hFF, 8'hEE);
        send_request(FUNC_REPLAY, 8'h00, 8'h00, 8'h00);
        send_request(FUNC_REPLAY, 8'hFF, 8'hFF, 8'hFF);
        configure(12'd31, 12'd1);
        send_request(FUNC_REPLAY, 8'h00, 8'h00, 8'h00);
        drain_requests();
    endtask

    task automatic test_output_backpressure();
        configure(12'd4, 12'd3);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold = 300;
        for (int i = 0; i < 40; i++)
            send_request(replaying_now, rand_color(), rand_color(), rand_color());
        drain_requests();
    endtask

    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] scale_pick;
        logic [CFG_DATA_W-1:0] width_pick;
        int                    count;
        int                    odd_scales [5];
        int                    odd_widths [5];
        odd_scales = '{0, 15, 16, 17, 31};
        odd_widths = '{0, 1, 2048, 2049, 4095};
        for (int ph = 0; ph < 12; ph++)
        begin
            if ($urandom_range(0, 3) == 0)
                scale_pick = CFG_DATA_W'(odd_scales[$urandom_range(0, 4)]);
            else
                scale_pick = CFG_DATA_W'($urandom_range(1, 8));
            // the upper data bits fall outside the scale register
            if ($urandom_range(0, 1) == 1)
                scale_pick[CFG_DATA_W-1:SCALE_W] = (CFG_DATA_W - SCALE_W)'($urandom);
            if ($urandom_range(0, 4) == 0)
                width_pick = CFG_DATA_W'(odd_widths[$urandom_range(0, 4)]);
            else
                width_pick = CFG_DATA_W'($urandom_range(1, 10));
            configure(scale_pick, width_pick);
            tx_idle = ph[0];
            rx_idle = ph[1];
            count = (clamp_width(width_reg) > 16) ? 10 : 30;
            for (int i = 0; i < count; i++)
            begin
                logic f;
                f = replaying_now;
                if ($urandom_range(0, 9) == 0)
                    f = ~f;
                send_request(f, rand_color(), rand_color(), rand_color());
            end
        end
        drain_requests();
    endtask

    // result sink: random stalls, plus one long hold-off when asked
    initial
    begin : result_sink
        int gap;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (rx_hold > 0)
            begin
                gap     = rx_hold;
                rx_hold = 0;
            end
            else
                gap = rx_idle ? $urandom_range(0, 15) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    always @(posedge clk)
    begin
        upscale_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: expected no result, got kind %0d rgb %02h%02h%02h",
                         $time, kind, out_red, out_green, out_blue,
                         " row_done %0b last %0b", row_done, last);
            end
            else
            begin
                want = expected_results.pop_front();
                if (kind !== want.kind || out_red !== want.red || out_green !== want.green ||
                    out_blue !== want.blue || row_done !== want.row_done ||
                    last !== want.last)
                begin
                    mismatches++;
                    $display("%0t: expected kind %0d rgb %02h%02h%02h row_done %0b last %0b,",
                             $time, want.kind, want.red, want.green, want.blue,
                             want.row_done, want.last,
                             " got kind %0d rgb %02h%02h%02h row_done %0b last %0b",
                             kind, out_red, out_green, out_blue, row_done, last);
                end
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_output_backpressure();
        test_random_traffic();
        drain_requests();
        repeat (20) @(posedge clk);
        if (expected_results.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("status: fail");
        $finish;
    end

endmodule
